[rtl/fhc_pkg.sv]
// ----------------------------------------------------------------------------
// fhc_pkg: shared types and constants of the font handle cache
// Entry and control types for the cell row, and the slot-to-base mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package fhc_pkg;

   localparam int ENTRIES     = 10;
   localparam int SLOT_W      = $clog2(ENTRIES);
   localparam int KEY_W       = 20;
   localparam int WIN_W       = 8;
   localparam int BASE_W      = 12;
   localparam int BASE_ORIGIN = 1000;
   localparam int BASE_STEP   = 260;

   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [SLOT_W-1:0] slot;
   } fhc_entry_type;

   typedef struct packed {
      logic move_front;
      logic shift_all;
      logic remove;
   } fhc_ctrl_type;

   typedef struct packed {
      logic key_hit;
      logic win_hit;
   } fhc_match_type;

   // base of slot k is 1000 + 260*(k+1), kept to 12 bits
   function automatic logic [BASE_W-1:0] slot_base(input logic [SLOT_W-1:0] k);
      int b;
      b = BASE_ORIGIN + BASE_STEP * (int'(k) + 1);
      return b[BASE_W-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/fhc_cell.sv]
// ----------------------------------------------------------------------------
// fhc_cell: one entry of the most-recently-used row
// Holds a key and slot, compares against the request, and loads from its
// left or right neighbor when the row shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module fhc_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  fhc_pkg::fhc_ctrl_type        ctrl,
   input  logic [fhc_pkg::KEY_W-1:0]    req_key,
   input  fhc_pkg::fhc_entry_type       left_entry,
   input  fhc_pkg::fhc_entry_type       right_entry,
   input  logic                         key_seen_in,
   input  logic                         win_seen_in,
   output fhc_pkg::fhc_entry_type       entry,
   output logic                         key_seen_out,
   output logic                         win_seen_out,
   output fhc_pkg::fhc_match_type       match
);
   import fhc_pkg::*;

   logic              valid_ff, valid_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              take_left;
   logic              take_right;

   assign match.key_hit = valid_ff && (key_ff == req_key);
   assign match.win_hit = valid_ff &&
                          (key_ff[KEY_W-1 -: WIN_W] == req_key[KEY_W-1 -: WIN_W]);

   // key hits ripple toward the front, window hits toward the back
   assign key_seen_out = key_seen_in | match.key_hit;
   assign win_seen_out = win_seen_in | match.win_hit;

   assign take_left  = ctrl.shift_all | (ctrl.move_front & key_seen_out);
   assign take_right = ctrl.remove & win_seen_out;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      slot_in  = slot_ff;
      if (take_left) begin
         valid_in = left_entry.valid;
         key_in   = left_entry.key;
         slot_in  = left_entry.slot;
      end else if (take_right) begin
         valid_in = right_entry.valid;
         key_in   = right_entry.key;
         slot_in  = right_entry.slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      slot_ff <= slot_in;
   end

   assign entry = '{valid: valid_ff, key: key_ff, slot: slot_ff};

endmodule

`default_nettype wire

[rtl/font_handle_lru_cache.sv]
// ----------------------------------------------------------------------------
// font_handle_lru_cache: move-to-front font handle cache
// A row of ten cells keeps font keys in most-recently-used order, each
// with the handle slot it owns; lookups hit or allocate, releases drop a
// window's fonts.
//
// Usage:
//   Request channel: drive req_* and raise start; the transfer happens at
//   the edge where start is high and busy is low. busy stays high while the
//   request is worked on.
//   Result channel: each result is on rsp_* for one cycle with rsp_strobe
//   high; the receiver takes every result and cannot stall the block.
//   Lookup: one result, computed in the compare-and-shift state of the cell
//   row and registered onto rsp_*; it is shown while the next request may
//   already be taken.
//   Release: one result per freed base, one per cycle, removed front to
//   back; a single result with rsp_freed low when the window owns nothing.
//   rsp_last marks the final result of each request.
//   Reset: synchronous, active high; clears all valid bits so the cache
//   comes up empty, and returns to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module font_handle_lru_cache (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_req_type,
   input  logic [fhc_pkg::WIN_W-1:0]     req_window_id,
   input  logic                          req_italic,
   input  logic                          req_bold,
   input  logic [7:0]                    req_font_size,
   input  logic [1:0]                    req_font_family,
   output logic                          rsp_strobe,
   output logic [fhc_pkg::BASE_W-1:0]    rsp_list_base,
   output logic                          rsp_hit,
   output logic                          rsp_freed,
   output logic [fhc_pkg::BASE_W-1:0]    rsp_freed_base,
   output logic                          rsp_last
);
   import fhc_pkg::*;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_LOOKUP  = 2'd1;
   localparam logic [1:0] ST_RELEASE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [KEY_W-1:0]  req_key_ff, req_key_in;

   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [BASE_W-1:0] rsp_list_base_ff, rsp_list_base_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic              rsp_freed_ff, rsp_freed_in;
   logic [BASE_W-1:0] rsp_freed_base_ff, rsp_freed_base_in;
   logic              rsp_last_ff, rsp_last_in;

   fhc_ctrl_type      ctrl;
   fhc_entry_type     cell_entry [ENTRIES];
   fhc_match_type     cell_match [ENTRIES];
   fhc_entry_type     front_entry;
   fhc_entry_type     empty_entry;
   logic [ENTRIES:0]  key_chain;
   logic [ENTRIES:0]  win_chain;

   logic [ENTRIES-1:0] key_hit_vec;
   logic [ENTRIES-1:0] win_hit_vec;
   logic [ENTRIES-1:0] valid_vec;
   logic [ENTRIES-1:0] used_vec;
   logic [SLOT_W-1:0]  hit_slot;
   logic [SLOT_W-1:0]  first_win_slot;
   logic [SLOT_W-1:0]  free_slot;
   logic [SLOT_W-1:0]  last_slot;
   logic [SLOT_W-1:0]  new_slot;
   logic               any_hit;
   logic               any_win;
   logic               more_win;
   logic               full;

   // ------------------------------------------------------------------
   // Cell row: cell 0 is the most recent entry
   // ------------------------------------------------------------------
   assign key_chain[ENTRIES] = 1'b0;
   assign win_chain[0]       = 1'b0;
   assign empty_entry        = '{valid: 1'b0, key: '0, slot: '0};

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      fhc_entry_type left_e;
      fhc_entry_type right_e;

      if (i == 0) begin : g_first
         assign left_e = front_entry;
      end else begin : g_mid_left
         assign left_e = cell_entry[i-1];
      end

      if (i == ENTRIES - 1) begin : g_last
         assign right_e = empty_entry;
      end else begin : g_mid_right
         assign right_e = cell_entry[i+1];
      end

      fhc_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .req_key      (req_key_ff),
         .left_entry   (left_e),
         .right_entry  (right_e),
         .key_seen_in  (key_chain[i+1]),
         .win_seen_in  (win_chain[i]),
         .entry        (cell_entry[i]),
         .key_seen_out (key_chain[i]),
         .win_seen_out (win_chain[i+1]),
         .match        (cell_match[i])
      );

      assign key_hit_vec[i] = cell_match[i].key_hit;
      assign win_hit_vec[i] = cell_match[i].win_hit;
      assign valid_vec[i]   = cell_entry[i].valid;
   end

   assign any_hit   = key_chain[0];
   assign any_win   = win_chain[ENTRIES];
   assign full      = valid_vec[ENTRIES-1];
   assign last_slot = cell_entry[ENTRIES-1].slot;
   // another window match remains after the front-most one
   assign more_win  = |(win_hit_vec & (win_hit_vec - ENTRIES'(1)));

   // Pick the hit slot and the front-most window match (both one-hot).
   always_comb begin
      hit_slot       = '0;
      first_win_slot = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (cell_match[i].key_hit) begin
            hit_slot = hit_slot | cell_entry[i].slot;
         end
         if (cell_match[i].win_hit && !win_chain[i]) begin
            first_win_slot = first_win_slot | cell_entry[i].slot;
         end
      end
   end

   // Mark slots held by live entries, then take the lowest free one.
   always_comb begin
      used_vec  = '0;
      free_slot = '0;
      for (int k = 0; k < ENTRIES; k++) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (cell_entry[i].valid && (cell_entry[i].slot == SLOT_W'(k))) begin
               used_vec[k] = 1'b1;
            end
         end
      end
      for (int k = ENTRIES - 1; k >= 0; k--) begin
         if (!used_vec[k]) begin
            free_slot = SLOT_W'(k);
         end
      end
   end

   // hit keeps its slot, a miss on a full row reuses the evicted slot
   assign new_slot    = any_hit ? hit_slot : (full ? last_slot : free_slot);
   assign front_entry = '{valid: 1'b1, key: req_key_ff, slot: new_slot};

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in          = state_ff;
      req_key_in        = req_key_ff;
      ctrl              = '0;
      rsp_strobe_in     = 1'b0;
      rsp_list_base_in  = '0;
      rsp_hit_in        = 1'b0;
      rsp_freed_in      = 1'b0;
      rsp_freed_base_in = '0;
      rsp_last_in       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_key_in = {req_window_id, req_italic, req_bold,
                             req_font_size, req_font_family};
               state_in   = req_req_type ? ST_RELEASE : ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // hit: rotate the entry to the front; miss: push the row back
            ctrl.move_front  = any_hit;
            ctrl.shift_all   = !any_hit;
            rsp_strobe_in    = 1'b1;
            rsp_list_base_in = slot_base(new_slot);
            rsp_hit_in       = any_hit;
            rsp_last_in      = 1'b1;
            if (!any_hit && full) begin
               rsp_freed_in      = 1'b1;
               rsp_freed_base_in = slot_base(last_slot);
            end
            state_in = ST_IDLE;
         end
         ST_RELEASE: begin
            rsp_strobe_in = 1'b1;
            if (any_win) begin
               // drop the front-most match and close the gap
               ctrl.remove       = 1'b1;
               rsp_freed_in      = 1'b1;
               rsp_freed_base_in = slot_base(first_win_slot);
               rsp_last_in       = !more_win;
               if (!more_win) begin
                  state_in = ST_IDLE;
               end
            end else begin
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_key_ff        <= req_key_in;
      rsp_list_base_ff  <= rsp_list_base_in;
      rsp_hit_ff        <= rsp_hit_in;
      rsp_freed_ff      <= rsp_freed_in;
      rsp_freed_base_ff <= rsp_freed_base_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_list_base  = rsp_list_base_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_freed      = rsp_freed_ff;
   assign rsp_freed_base = rsp_freed_base_ff;
   assign rsp_last       = rsp_last_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_key_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(key_hit_vec))
      else $error("font key held by more than one cell");

   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec & (valid_vec + ENTRIES'(1))) == '0))
      else $error("live entries do not form a prefix of the row");

   a_hit_no_free: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_hit |-> !rsp_freed)
      else $error("lookup hit reported a freed base");

   a_release_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RELEASE) && !any_win |=> rsp_strobe && rsp_last && !rsp_freed)
      else $error("release without match did not close the request");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not make the block busy");

endmodule

`default_nettype wire

[test/font_handle_lru_cache_tb.sv]
// ----------------------------------------------------------------------------
// font_handle_lru_cache_tb: self-checking bench for the font handle cache
// Drives lookups and window releases through the start/busy command port,
// tracks the cache contents in its own most-recently-used list and checks
// every strobed result, field by field, against the predicted handle bases.
// ----------------------------------------------------------------------------

module font_handle_lru_cache_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import fhc_pkg::ENTRIES;
   import fhc_pkg::KEY_W;
   import fhc_pkg::SLOT_W;
   import fhc_pkg::WIN_W;
   import fhc_pkg::BASE_W;

   // request kinds as the block decodes req_req_type
   typedef enum bit {
      REQ_LOOKUP  = 1'b0,
      REQ_RELEASE = 1'b1
   } req_kind_type;

   localparam int HANDLE_ORIGIN = 1000;
   localparam int HANDLE_STEP   = 260;
   localparam int RANDOM_ITEMS  = 350;
   localparam int POOL_KEYS     = 14;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 16;
   localparam int MAX_PRINTS    = 40;

   typedef struct {
      req_kind_type      kind;
      bit [WIN_W-1:0]    window;
      bit                italic;
      bit                bold;
      bit [7:0]          pt_size;
      bit [1:0]          family;
   } font_req_type;

   typedef struct {
      bit [BASE_W-1:0]   list_base;
      bit                hit;
      bit                freed;
      bit [BASE_W-1:0]   freed_base;
      bit                last;
   } font_rsp_type;

   // -------------------------------------------------------------------------
   // Handle tracker: keeps its own copy of the cache row and the queue of
   // results still owed by the block.
   // -------------------------------------------------------------------------
   class fhc_handle_tracker;
      bit [KEY_W-1:0]  key_row[ENTRIES];
      bit [SLOT_W-1:0] slot_row[ENTRIES];
      int              fill;
      font_rsp_type    due_results[$];
      int              errors;

      function new();
         fill   = 0;
         errors = 0;
      endfunction

      function bit [BASE_W-1:0] handle_base(int k);
         int b;
         b = HANDLE_ORIGIN + HANDLE_STEP * (k + 1);
         return b[BASE_W-1:0];
      endfunction

      // shift entries 0..pos-1 down by one, put key at the front
      function void to_front(int pos, bit [KEY_W-1:0] key, bit [SLOT_W-1:0] slot);
         for (int j = pos; j > 0; j--) begin
            key_row[j]  = key_row[j-1];
            slot_row[j] = slot_row[j-1];
         end
         key_row[0]  = key;
         slot_row[0] = slot;
      endfunction

      function void push_result(bit [BASE_W-1:0] base, bit hit, bit freed,
                                bit [BASE_W-1:0] fbase, bit last);
         font_rsp_type r;
         r.list_base  = base;
         r.hit        = hit;
         r.freed      = freed;
         r.freed_base = fbase;
         r.last       = last;
         due_results.push_back(r);
      endfunction

      // work out the results of one accepted transfer
      function void note_request(font_req_type q);
         bit [KEY_W-1:0]  key;
         bit [SLOT_W-1:0] slot;
         bit              freed;
         bit [BASE_W-1:0] fbase;
         bit              used;
         int              kept;
         int              n;
         key = {q.window, q.italic, q.bold, q.pt_size, q.family};
         if (q.kind == REQ_LOOKUP) begin
            for (int i = 0; i < fill; i++) begin
               if (key_row[i] == key) begin
                  slot = slot_row[i];
                  to_front(i, key, slot);
                  push_result(handle_base(slot), 1'b1, 1'b0, '0, 1'b1);
                  return;
               end
            end
            freed = 1'b0;
            fbase = '0;
            slot  = '0;
            if (fill == ENTRIES) begin
               // full: the oldest entry gives up its slot
               slot  = slot_row[ENTRIES-1];
               freed = 1'b1;
               fbase = handle_base(slot);
               fill  = ENTRIES - 1;
            end else begin
               // lowest slot no live entry holds
               for (int k = 0; k < ENTRIES; k++) begin
                  used = 1'b0;
                  for (int i = 0; i < fill; i++)
                     if (slot_row[i] == k) used = 1'b1;
                  if (!used) begin
                     slot = SLOT_W'(k);
                     break;
                  end
               end
            end
            to_front(fill, key, slot);
            fill++;
            push_result(handle_base(slot), 1'b0, freed, fbase, 1'b1);
         end else begin
            kept = 0;
            n    = 0;
            for (int i = 0; i < fill; i++) begin
               if (key_row[i][KEY_W-1 -: WIN_W] == q.window) begin
                  push_result('0, 1'b0, 1'b1, handle_base(slot_row[i]), 1'b0);
                  n++;
               end else begin
                  key_row[kept]  = key_row[i];
                  slot_row[kept] = slot_row[i];
                  kept++;
               end
            end
            fill = kept;
            if (n == 0)
               push_result('0, 1'b0, 1'b0, '0, 1'b1);
            else
               due_results[due_results.size()-1].last = 1'b1;
         end
      endfunction

      task report(string msg);
         errors++;
         if (errors <= MAX_PRINTS)
            $display("%0t ns: mismatch: %s", $time, msg);
      endtask

      task check_result(font_rsp_type got);
         font_rsp_type want;
         if (due_results.size() == 0) begin
            report($sformatf("result with nothing pending (base %0d freed_base %0d)",
                             got.list_base, got.freed_base));
            return;
         end
         want = due_results.pop_front();
         if (got.list_base != want.list_base)
            report($sformatf("list_base %0d, predicted %0d", got.list_base, want.list_base));
         if (got.hit != want.hit)
            report($sformatf("hit %0b, predicted %0b", got.hit, want.hit));
         if (got.freed != want.freed)
            report($sformatf("freed %0b, predicted %0b", got.freed, want.freed));
         if (got.freed_base != want.freed_base)
            report($sformatf("freed_base %0d, predicted %0d",
                             got.freed_base, want.freed_base));
         if (got.last != want.last)
            report($sformatf("last %0b, predicted %0b", got.last, want.last));
      endtask

      function int pending();
         return due_results.size();
      endfunction

      task close_out();
         if (due_results.size() != 0)
            report($sformatf("%0d results never arrived", due_results.size()));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // -------------------------------------------------------------------------
   logic              clock;
   logic              reset           = 1'b1;
   logic              start           = 1'b0;
   logic              busy;
   logic              req_req_type    = 1'b0;
   logic [WIN_W-1:0]  req_window_id   = '0;
   logic              req_italic      = 1'b0;
   logic              req_bold        = 1'b0;
   logic [7:0]        req_font_size   = '0;
   logic [1:0]        req_font_family = '0;
   logic              rsp_strobe;
   logic [BASE_W-1:0] rsp_list_base;
   logic              rsp_hit;
   logic              rsp_freed;
   logic [BASE_W-1:0] rsp_freed_base;
   logic              rsp_last;

   font_handle_lru_cache u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_req_type    (req_req_type),
      .req_window_id   (req_window_id),
      .req_italic      (req_italic),
      .req_bold        (req_bold),
      .req_font_size   (req_font_size),
      .req_font_family (req_font_family),
      .rsp_strobe      (rsp_strobe),
      .rsp_list_base   (rsp_list_base),
      .rsp_hit         (rsp_hit),
      .rsp_freed       (rsp_freed),
      .rsp_freed_base  (rsp_freed_base),
      .rsp_last        (rsp_last)
   );

   fhc_handle_tracker tracker = new();
   font_req_type      key_pool[POOL_KEYS];
   int                cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run; the limit is many times the slowest legal run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Take every strobed result at the edge that ends its cycle; the values
   // read here are the ones from before the edge.
   always @(posedge clock) begin
      font_rsp_type got;
      if (!reset && rsp_strobe) begin
         got.list_base  = rsp_list_base;
         got.hit        = rsp_hit;
         got.freed      = rsp_freed;
         got.freed_base = rsp_freed_base;
         got.last       = rsp_last;
         tracker.check_result(got);
      end
   end

   function automatic font_req_type make_req(req_kind_type kind, int window, int italic,
                                             int bold, int pt_size, int family);
      font_req_type q;
      q.kind    = kind;
      q.window  = WIN_W'(window);
      q.italic  = 1'(italic);
      q.bold    = 1'(bold);
      q.pt_size = 8'(pt_size);
      q.family  = 2'(family);
      return q;
   endfunction

   // Present one request and hold it until the transfer edge, i.e. the
   // first edge that sees busy low. Called right after an edge, so start
   // is assigned only once in this step.
   task automatic drive_request(font_req_type q);
      start           <= 1'b1;
      req_req_type    <= q.kind;
      req_window_id   <= q.window;
      req_italic      <= q.italic;
      req_bold        <= q.bold;
      req_font_size   <= q.pt_size;
      req_font_family <= q.family;
      do @(posedge clock); while (busy);
      tracker.note_request(q);
   endtask

   // Drop start and leave the request port idle.
   task automatic hold_off(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Mostly lookups from a small key pool spread over a few windows, so
   // hits, evictions and multi-entry releases are frequent; the rest are
   // full-range keys and releases of any window.
   function automatic font_req_type random_request();
      font_req_type q;
      int           pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         q = make_req(REQ_RELEASE,
                      ($urandom_range(0, 4) != 0) ? $urandom_range(0, 3)
                                                  : $urandom_range(0, 255),
                      $urandom_range(0, 1), $urandom_range(0, 1),
                      $urandom_range(0, 255), $urandom_range(0, 3));
      end else if (pick < 85) begin
         q = key_pool[$urandom_range(0, POOL_KEYS-1)];
      end else begin
         q = make_req(REQ_LOOKUP, $urandom_range(0, 255), $urandom_range(0, 1),
                      $urandom_range(0, 1), $urandom_range(0, 255),
                      $urandom_range(0, 3));
      end
      return q;
   endfunction

   initial begin
      bit quiet;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // -- directed part ------------------------------------------------------
      // release on an empty cache: single result with nothing freed
      drive_request(make_req(REQ_RELEASE, 5, 0, 0, 0, 0));
      // all-zero key misses, then hits
      drive_request(make_req(REQ_LOOKUP, 0, 0, 0, 0, 0));
      drive_request(make_req(REQ_LOOKUP, 0, 0, 0, 0, 0));
      // all-ones key, then fill the row to ten entries
      drive_request(make_req(REQ_LOOKUP, 255, 1, 1, 255, 3));
      drive_request(make_req(REQ_LOOKUP, 1, 0, 1, 12, 1));
      drive_request(make_req(REQ_LOOKUP, 1, 1, 0, 12, 1));
      drive_request(make_req(REQ_LOOKUP, 1, 0, 0, 14, 2));
      drive_request(make_req(REQ_LOOKUP, 2, 0, 0, 10, 0));
      drive_request(make_req(REQ_LOOKUP, 2, 1, 1, 128, 3));
      drive_request(make_req(REQ_LOOKUP, 3, 0, 0, 64, 1));
      drive_request(make_req(REQ_LOOKUP, 3, 0, 1, 64, 2));
      drive_request(make_req(REQ_LOOKUP, 4, 1, 0, 32, 0));
      // hit deep in the row moves it to the front
      drive_request(make_req(REQ_LOOKUP, 0, 0, 0, 0, 0));
      // full row: two misses evict the oldest entries and reuse their bases
      drive_request(make_req(REQ_LOOKUP, 6, 0, 0, 20, 1));
      drive_request(make_req(REQ_LOOKUP, 7, 1, 1, 20, 2));
      // adjacent entries of one window released together, then none left
      drive_request(make_req(REQ_RELEASE, 1, 1, 1, 255, 3));
      drive_request(make_req(REQ_RELEASE, 1, 0, 0, 0, 0));
      // miss after a release takes the lowest free base
      drive_request(make_req(REQ_LOOKUP, 8, 0, 0, 255, 3));
      drive_request(make_req(REQ_RELEASE, 0, 0, 0, 0, 0));
      drive_request(make_req(REQ_RELEASE, 255, 0, 0, 0, 0));
      drive_request(make_req(REQ_LOOKUP, 255, 1, 1, 255, 3));
      drive_request(make_req(REQ_RELEASE, 255, 1, 1, 255, 3));

      // -- random part --------------------------------------------------------
      foreach (key_pool[i])
         key_pool[i] = make_req(REQ_LOOKUP, $urandom_range(0, 3), $urandom_range(0, 1),
                                $urandom_range(0, 1), $urandom_range(0, 255),
                                $urandom_range(0, 3));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // back-to-back stretch in the middle, otherwise idle about 7%
         quiet = (n >= 120 && n < 220);
         if (!quiet && $urandom_range(0, 99) < 7)
            hold_off($urandom_range(1, 6));
         drive_request(random_request());
      end
      start <= 1'b0;

      // -- drain --------------------------------------------------------------
      while (tracker.pending() != 0) @(posedge clock);
      // catch any stray trailing result
      repeat (DRAIN_CYCLES) @(posedge clock);
      tracker.close_out();

      if (tracker.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[files.f]
rtl/fhc_pkg.sv
rtl/fhc_cell.sv
rtl/font_handle_lru_cache.sv
test/font_handle_lru_cache_tb.sv
